>>> hw/rtl/csmab_pkg.sv
// Shared types and constants for the CSMA-CA backoff controller.
// Used by csmab_engine and csma_ca_backoff_controller; no dependencies.
package csmab_pkg;

    localparam int unsigned RND_W   = 15;
    localparam int unsigned DELAY_W = 25;
    localparam int unsigned CNT_W   = 9;

    localparam logic [7:0] BCAST_ADDR = 8'hFF;

    // Configuration register indexes
    localparam logic [2:0] CFG_EXP_LIMIT    = 3'd0;
    localparam logic [2:0] CFG_MAX_BACKOFFS = 3'd1;
    localparam logic [2:0] CFG_UNIT_TICKS   = 3'd2;
    localparam logic [2:0] CFG_ACK_WAIT     = 3'd3;
    localparam logic [2:0] CFG_ACK_REQ      = 3'd4;

    // Register reset values
    localparam logic [3:0]  RST_EXP_LIMIT    = 4'd4;
    localparam logic [7:0]  RST_MAX_BACKOFFS = 8'd15;
    localparam logic [9:0]  RST_UNIT_TICKS   = 10'd10;
    localparam logic [15:0] RST_ACK_WAIT     = 16'd3900;
    localparam logic        RST_ACK_REQ      = 1'b1;

    // Channel assessment answers; any other code counts as an error
    localparam logic [1:0] CS_FREE = 2'd0;
    localparam logic [1:0] CS_BUSY = 2'd1;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_BACKOFF = 4'b0010,
        PH_CAD     = 4'b0100,
        PH_ACK     = 4'b1000
    } t_phase;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_CAD   = 2'd2,
        KIND_ACK   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ACT_CAD_REQ = 2'd0,
        ACT_SEND    = 2'd1,
        ACT_REPORT  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_MAX_RETRIES = 2'd1,
        ST_TX_ERROR    = 2'd2
    } t_status;

    typedef struct packed {
        logic [3:0]  exp_limit;
        logic [7:0]  max_backoffs;
        logic [9:0]  unit_ticks;
        logic [15:0] ack_wait;
        logic        ack_req_en;
    } t_cfg;

    typedef struct packed {
        t_kind            kind;
        logic [7:0]       frame_no;
        logic [7:0]       hop_addr;
        logic             ack_frame_mode;
        logic             use_default_exponent;
        logic [3:0]       start_exponent;
        logic [1:0]       channel_status;
        logic [7:0]       ack_number;
        logic [RND_W-1:0] random_bits;
    } t_event;

    typedef struct packed {
        t_action          action;
        logic             done_res;
        t_status          status;
        logic [7:0]       frame_id;
        logic [CNT_W-1:0] attempts;
    } t_result;

    // Low-bit mask of 2^e - 1 over the random field
    function automatic logic [RND_W-1:0] backoff_mask(input logic [3:0] e);
        logic [RND_W-1:0] m;
        for (int i = 0; i < RND_W; i++) begin
            m[i] = (i < int'(e));
        end
        return m;
    endfunction

endpackage

>>> hw/rtl/csmab_engine.sv
// Backoff state and per-item update for the CSMA-CA controller.
// Depends on csmab_pkg; state advances only on i_fire.
module csmab_engine
    import csmab_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_event  i_evt,
    input  t_cfg    i_cfg,
    output logic    o_res_valid,
    output t_result o_res
);

    t_phase             r_phase, n_phase;
    logic [3:0]         r_exp, n_exp;
    logic [CNT_W-1:0]   r_bc, n_bc;
    logic [DELAY_W-1:0] r_dl, n_dl;
    logic [15:0]        r_at, n_at;
    logic               r_mis, n_mis;
    logic [7:0]         r_frame, n_frame;
    logic               r_wants, n_wants;
    logic               r_ackm, n_ackm;
    logic               r_lerr, n_lerr;

    logic               cs_err;
    logic               raise;
    logic [4:0]         exp_inc;
    logic [3:0]         exp_raised, exp_retry, exp_start, exp_bo;
    logic [RND_W-1:0]   masked;
    logic [DELAY_W-1:0] delay;
    logic               delay_zero;
    logic [CNT_W-1:0]   bc_inc;
    logic               giveup;
    logic [DELAY_W-1:0] dl_dec;
    logic [15:0]        at_dec;
    logic               do_retry, do_start_bo;
    t_action            res_action;
    logic               res_done;
    t_status            res_status;

    assign cs_err     = (i_evt.channel_status != CS_FREE) && (i_evt.channel_status != CS_BUSY);
    // only an assessment error retries without raising the exponent
    assign raise      = !((i_evt.kind == KIND_CAD) && cs_err);
    assign exp_inc    = {1'b0, r_exp} + 5'd1;
    assign exp_raised = (exp_inc < {1'b0, i_cfg.exp_limit}) ? exp_inc[3:0] : i_cfg.exp_limit;
    assign exp_retry  = raise ? exp_raised : r_exp;
    assign exp_start  = i_evt.use_default_exponent ? i_cfg.exp_limit : i_evt.start_exponent;
    assign exp_bo     = (i_evt.kind == KIND_START) ? exp_start : exp_retry;
    assign masked     = i_evt.random_bits & backoff_mask(exp_bo);
    assign delay      = {{(DELAY_W-10){1'b0}}, i_cfg.unit_ticks}
                      * {{(DELAY_W-RND_W){1'b0}}, masked};
    // zero test straight from the factors, off the multiplier path
    assign delay_zero = (i_cfg.unit_ticks == 10'd0) || (masked == '0);
    assign bc_inc     = r_bc + 9'd1;
    assign giveup     = bc_inc > {1'b0, i_cfg.max_backoffs};
    assign dl_dec     = (r_dl != '0) ? r_dl - 25'd1 : '0;
    assign at_dec     = (r_at != '0) ? r_at - 16'd1 : '0;

    always_comb begin
        n_phase     = r_phase;
        n_exp       = r_exp;
        n_bc        = r_bc;
        n_dl        = r_dl;
        n_at        = r_at;
        n_mis       = r_mis;
        n_frame     = r_frame;
        n_wants     = r_wants;
        n_ackm      = r_ackm;
        n_lerr      = r_lerr;
        o_res_valid = 1'b0;
        res_action  = ACT_CAD_REQ;
        res_done    = 1'b0;
        res_status  = ST_OK;
        do_retry    = 1'b0;
        do_start_bo = 1'b0;

        unique case (i_evt.kind)
            KIND_START: begin
                n_frame     = i_evt.frame_no;
                n_ackm      = i_evt.ack_frame_mode;
                n_exp       = exp_start;
                n_wants     = i_cfg.ack_req_en && !i_evt.ack_frame_mode
                              && (i_evt.hop_addr != BCAST_ADDR);
                n_bc        = '0;
                n_mis       = 1'b0;
                n_lerr      = 1'b0;
                n_at        = '0;
                do_start_bo = 1'b1;
            end
            KIND_TICK: begin
                if (r_phase == PH_BACKOFF) begin
                    n_dl = dl_dec;
                    if (dl_dec == '0) begin
                        n_phase     = PH_CAD;
                        o_res_valid = 1'b1;
                        res_action  = ACT_CAD_REQ;
                    end
                end else if (r_phase == PH_ACK) begin
                    n_at = at_dec;
                    if (at_dec == '0) begin
                        do_retry = 1'b1;
                    end
                end
            end
            KIND_CAD: begin
                if (r_phase == PH_CAD) begin
                    if (i_evt.channel_status == CS_FREE) begin
                        n_lerr      = 1'b0;
                        o_res_valid = 1'b1;
                        res_action  = ACT_SEND;
                        if (r_wants) begin
                            n_phase = PH_ACK;
                            n_at    = i_cfg.ack_wait;
                            n_mis   = 1'b0;
                        end else begin
                            n_phase  = PH_IDLE;
                            res_done = 1'b1;
                        end
                    end else begin
                        n_lerr   = cs_err;
                        do_retry = 1'b1;
                    end
                end
            end
            KIND_ACK: begin
                if (r_phase == PH_ACK) begin
                    if (i_evt.ack_number == r_frame) begin
                        n_phase     = PH_IDLE;
                        o_res_valid = 1'b1;
                        res_action  = ACT_REPORT;
                        res_done    = 1'b1;
                    end else if (!r_mis) begin
                        // first wrong ack just restarts the wait
                        n_mis = 1'b1;
                        n_at  = i_cfg.ack_wait;
                    end else begin
                        do_retry = 1'b1;
                    end
                end
            end
        endcase

        if (do_retry) begin
            n_bc  = bc_inc;
            n_exp = exp_retry;
            if (giveup) begin
                n_phase     = PH_IDLE;
                o_res_valid = 1'b1;
                res_action  = ACT_REPORT;
                res_done    = 1'b1;
                res_status  = (r_ackm && n_lerr) ? ST_TX_ERROR : ST_MAX_RETRIES;
            end else begin
                do_start_bo = 1'b1;
            end
        end

        if (do_start_bo) begin
            if (delay_zero) begin
                n_phase     = PH_CAD;
                n_dl        = '0;
                o_res_valid = 1'b1;
                res_action  = ACT_CAD_REQ;
            end else begin
                n_phase = PH_BACKOFF;
                n_dl    = delay;
            end
        end
    end

    assign o_res.action   = res_action;
    assign o_res.done_res = res_done;
    assign o_res.status   = res_status;
    assign o_res.frame_id = n_frame;
    assign o_res.attempts = n_bc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_exp   <= '0;
            r_bc    <= '0;
            r_dl    <= '0;
            r_at    <= '0;
            r_mis   <= 1'b0;
            r_frame <= '0;
            r_wants <= 1'b0;
            r_ackm  <= 1'b0;
            r_lerr  <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_exp   <= n_exp;
            r_bc    <= n_bc;
            r_dl    <= n_dl;
            r_at    <= n_at;
            r_mis   <= n_mis;
            r_frame <= n_frame;
            r_wants <= n_wants;
            r_ackm  <= n_ackm;
            r_lerr  <= n_lerr;
        end
    end

    a_backoff_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BACKOFF) |-> (r_dl != '0))
        else $error("backoff phase with no delay left");

    a_send_waits_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res_valid && (o_res.action == ACT_SEND) && !o_res.done_res)
        |=> (r_phase == PH_ACK))
        else $error("send without done did not enter ack wait");

    a_report_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res_valid && o_res.done_res) |=> (r_phase == PH_IDLE))
        else $error("finished attempt left controller busy");

endmodule

>>> hw/rtl/csma_ca_backoff_controller.sv
// CSMA-CA transmit controller: input register, engine, result register.
// Results are registered; input and result registers decouple stalls.
// Throughput: one item per cycle unless a held result stalls the engine.
// Reset (synchronous, active low): idle, registers at defaults, no results.
// Depends on csmab_pkg and csmab_engine.
module csma_ca_backoff_controller
    import csmab_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_kind,
    input  logic [7:0]       i_frame_no,
    input  logic [7:0]       i_hop_addr,
    input  logic             i_ack_frame_mode,
    input  logic             i_use_default_exponent,
    input  logic [3:0]       i_start_exponent,
    input  logic [1:0]       i_channel_status,
    input  logic [7:0]       i_ack_number,
    input  logic [RND_W-1:0] i_random_bits,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [1:0]       o_action,
    output logic             o_done_res,
    output logic [1:0]       o_status,
    output logic [7:0]       o_frame_id,
    output logic [CNT_W-1:0] o_attempts
);

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_event  r_evt;
    logic    r_out_valid;
    t_result r_out;
    logic    fire;
    logic    accept;
    logic    res_valid;
    t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.exp_limit    <= RST_EXP_LIMIT;
            r_cfg.max_backoffs <= RST_MAX_BACKOFFS;
            r_cfg.unit_ticks   <= RST_UNIT_TICKS;
            r_cfg.ack_wait     <= RST_ACK_WAIT;
            r_cfg.ack_req_en   <= RST_ACK_REQ;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_EXP_LIMIT:    r_cfg.exp_limit    <= i_cfg_data[3:0];
                CFG_MAX_BACKOFFS: r_cfg.max_backoffs <= i_cfg_data[7:0];
                CFG_UNIT_TICKS:   r_cfg.unit_ticks   <= i_cfg_data[9:0];
                CFG_ACK_WAIT:     r_cfg.ack_wait     <= i_cfg_data;
                CFG_ACK_REQ:      r_cfg.ack_req_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // item moves from input register into the engine when the result slot frees
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_evt.kind                 <= t_kind'(i_kind);
            r_evt.frame_no             <= i_frame_no;
            r_evt.hop_addr             <= i_hop_addr;
            r_evt.ack_frame_mode       <= i_ack_frame_mode;
            r_evt.use_default_exponent <= i_use_default_exponent;
            r_evt.start_exponent       <= i_start_exponent;
            r_evt.channel_status       <= i_channel_status;
            r_evt.ack_number           <= i_ack_number;
            r_evt.random_bits          <= i_random_bits;
        end
    end

    csmab_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_evt       (r_evt),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_action    = r_out.action;
    assign o_done_res  = r_out.done_res;
    assign o_status    = r_out.status;
    assign o_frame_id  = r_out.frame_id;
    assign o_attempts  = r_out.attempts;

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && res_valid) |=> o_out_valid)
        else $error("engine result not captured");

    a_no_fire_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !fire)
        else $error("engine advanced while result slot was held");

    a_ready_low_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid))
        else $error("input stalled with a free pipeline");

endmodule
